FILE: rtl/fis_pkg.sv
package fis_pkg;

  localparam logic [31:0] RATE_SCALE = 32'd4096000000;

  localparam logic [31:0] RESET_TOO_FAST = 32'd14286;
  localparam logic [31:0] RESET_TOO_SLOW = 32'd83333;

  typedef enum logic [1:0] {
    REG_TOO_FAST   = 2'd0,
    REG_TOO_SLOW   = 2'd1,
    REG_CHECK_FAST = 2'd2
  } fis_reg_t;

  typedef struct packed {
    logic [31:0] too_fast_us;
    logic [31:0] too_slow_us;
    logic        check_fast;
  } fis_cfg_t;

  // A request in the queue is either a good interval or the end of a run.
  typedef struct packed {
    logic        last;
    logic [31:0] interval;
  } fis_item_t;

endpackage

FILE: rtl/fis_queue.sv
module fis_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fis_pkg::fis_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fis_pkg::fis_item_t out_data
);
  import fis_pkg::*;

  fis_item_t   slots [4];
  logic [1:0]  wptr;
  logic [1:0]  rptr;
  logic [2:0]  fill;
  logic        push;
  logic        pop;

  assign in_ready  = (fill != 3'd4);
  assign out_valid = (fill != 3'd0);
  assign out_data  = slots[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 2'd1;
      end
      if (pop) begin
        rptr <= rptr + 2'd1;
      end
      if (push && !pop) begin
        fill <= fill + 3'd1;
      end else if (pop && !push) begin
        fill <= fill - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= in_data;
    end
  end

endmodule

FILE: rtl/fis_front.sv
module fis_front #(
  parameter int HISTORY_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  fis_pkg::fis_cfg_t  cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_stamp,
  output logic               q_valid,
  input  logic               q_ready,
  output fis_pkg::fis_item_t q_data
);
  import fis_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);
  localparam logic [FW-1:0] DEPTH_F   = FW'(HISTORY_DEPTH);
  localparam logic [FW-1:0] LIM_MAX   = FW'(HISTORY_DEPTH - 2);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_READ = 4'b0010,
    F_EVAL = 4'b0100,
    F_MARK = 4'b1000
  } front_state_t;

  front_state_t state;
  logic [31:0]  ring [HISTORY_DEPTH];
  logic [AW-1:0] write_slot;
  logic [FW-1:0] frames_seen;
  logic          zero_written;
  logic [31:0]   newer;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;
  logic          rd_ok;
  logic [AW-1:0] steps_left;
  logic          run_started;

  logic          accept;
  logic [FW-1:0] seen_next;
  logic [FW-1:0] lim;
  logic [31:0]   older;
  logic [31:0]   interval;
  logic          bad;
  logic          addr_ok;

  assign in_ready = (state == F_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    seen_next = (frames_seen < DEPTH_F) ? frames_seen + FW'(1) : frames_seen;
    lim       = (seen_next - FW'(1) > LIM_MAX) ? LIM_MAX : seen_next - FW'(1);
    older     = rd_ok ? rd_data : 32'd0;
    interval  = newer - older;
    bad       = (interval == 32'd0) || (interval > cfg.too_slow_us) ||
                (cfg.check_fast && (interval < cfg.too_fast_us));
    addr_ok   = (rd_addr == '0) ? zero_written :
                (FW'(rd_addr) < frames_seen);
  end

  always_comb begin
    q_valid          = 1'b0;
    q_data.last      = 1'b0;
    q_data.interval  = interval;
    case (state)
      F_EVAL: begin
        q_valid = !bad;
      end
      F_MARK: begin
        q_valid     = 1'b1;
        q_data.last = 1'b1;
      end
      default: begin
        q_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ring[write_slot] <= in_stamp;
    end
    rd_data <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      write_slot   <= AW'(1);
      frames_seen  <= FW'(1);
      zero_written <= 1'b0;
      run_started  <= 1'b0;
      rd_ok        <= 1'b0;
      rd_addr      <= '0;
      steps_left   <= '0;
      newer        <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            newer       <= in_stamp;
            write_slot  <= (write_slot == LAST_SLOT) ? '0 : write_slot + AW'(1);
            frames_seen <= seen_next;
            if (write_slot == '0) begin
              zero_written <= 1'b1;
            end
            rd_addr     <= (write_slot == '0) ? LAST_SLOT : write_slot - AW'(1);
            steps_left  <= lim[AW-1:0];
            run_started <= 1'b0;
            state       <= F_READ;
          end
        end
        F_READ: begin
          rd_ok <= addr_ok;
          state <= F_EVAL;
        end
        F_EVAL: begin
          if (bad) begin
            if (run_started || steps_left == '0) begin
              state <= F_MARK;
            end else begin
              newer      <= older;
              rd_addr    <= (rd_addr == '0) ? LAST_SLOT : rd_addr - AW'(1);
              steps_left <= steps_left - AW'(1);
              state      <= F_READ;
            end
          end else if (q_ready) begin
            run_started <= 1'b1;
            if (steps_left == '0) begin
              state <= F_MARK;
            end else begin
              newer      <= older;
              rd_addr    <= (rd_addr == '0) ? LAST_SLOT : rd_addr - AW'(1);
              steps_left <= steps_left - AW'(1);
              state      <= F_READ;
            end
          end
        end
        F_MARK: begin
          if (q_ready) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/fis_div.sv
module fis_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        half,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [6:0]  remaining;
  logic [31:0] rem;
  logic [63:0] dvd;
  logic [31:0] dsr;
  logic [32:0] shifted;
  logic        fits;

  assign shifted  = {rem, dvd[63]};
  assign fits     = (shifted >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        remaining <= half ? 7'd32 : 7'd64;
      end else if (remaining != '0) begin
        remaining <= remaining - 7'd1;
        if (remaining == 7'd1) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      dvd      <= half ? {dividend[31:0], 32'd0} : dividend;
      quotient <= '0;
    end else if (remaining != '0) begin
      rem      <= fits ? 32'(shifted - {1'b0, dsr}) : shifted[31:0];
      dvd      <= {dvd[62:0], 1'b0};
      quotient <= {quotient[62:0], fits};
    end
  end

endmodule

FILE: rtl/fis_back.sv
module fis_back #(
  parameter int HISTORY_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  fis_pkg::fis_item_t q_data,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [71:0]        m_tdata,
  output logic               m_tuser
);
  import fis_pkg::*;

  localparam int CW = $clog2(HISTORY_DEPTH);

  typedef enum logic [7:0] {
    B_IDLE = 8'b00000001,
    B_RATE = 8'b00000010,
    B_MEAN = 8'b00000100,
    B_MUL  = 8'b00001000,
    B_ACC  = 8'b00010000,
    B_FDIV = 8'b00100000,
    B_SQRT = 8'b01000000,
    B_DONE = 8'b10000000
  } back_state_t;

  back_state_t state;
  logic [CW-1:0] cnt;
  logic [31:0]   mean;
  logic [63:0]   m2;
  logic [31:0]   x;
  logic          ge;
  logic [31:0]   dmag;
  logic [63:0]   prod;
  logic [63:0]   sq_v;
  logic [63:0]   sq_res;
  logic [63:0]   sq_bit;
  logic [31:0]   res_mean;
  logic [31:0]   res_dev;
  logic [5:0]    res_count;
  logic          res_valid;

  logic          div_start;
  logic          div_half;
  logic [63:0]   div_dividend;
  logic [31:0]   div_divisor;
  logic          div_done;
  logic [63:0]   div_q;

  logic [31:0]   xq;
  logic          ge_c;
  logic [31:0]   rmag;
  logic [64:0]   m2_sum;
  logic [63:0]   sq_t;
  logic          sq_fit;
  logic [31:0]   cnt_wide;

  fis_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .half     (div_half),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q_ready  = (state == B_IDLE);
  assign cnt_wide = 32'(cnt);

  always_comb begin
    xq     = div_q[31:0];
    ge_c   = (xq >= mean);
    rmag   = ge ? x - mean : mean - x;
    m2_sum = {1'b0, m2} + {1'b0, prod};
    sq_t   = sq_res + sq_bit;
    sq_fit = (sq_v >= sq_t);
  end

  always_comb begin
    div_start    = 1'b0;
    div_half     = 1'b1;
    div_dividend = {32'd0, RATE_SCALE};
    div_divisor  = q_data.interval;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          if (!q_data.last) begin
            div_start = 1'b1;
          end else if (cnt != '0) begin
            div_start    = 1'b1;
            div_half     = 1'b0;
            div_dividend = m2;
            div_divisor  = cnt_wide;
          end
        end
      end
      B_RATE: begin
        div_start    = div_done;
        div_dividend = {32'd0, ge_c ? xq - mean : mean - xq};
        div_divisor  = cnt_wide;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      cnt      <= '0;
      mean     <= '0;
      m2       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != B_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            if (!q_data.last) begin
              cnt   <= cnt + CW'(1);
              state <= B_RATE;
            end else if (cnt != '0) begin
              state <= B_FDIV;
            end else begin
              res_mean  <= '0;
              res_dev   <= '0;
              res_count <= '0;
              res_valid <= 1'b0;
              state     <= B_DONE;
            end
          end
        end
        B_RATE: begin
          if (div_done) begin
            x     <= xq;
            ge    <= ge_c;
            dmag  <= ge_c ? xq - mean : mean - xq;
            state <= B_MEAN;
          end
        end
        B_MEAN: begin
          if (div_done) begin
            mean  <= ge ? mean + div_q[31:0] : mean - div_q[31:0];
            state <= B_MUL;
          end
        end
        B_MUL: begin
          prod  <= 64'(dmag) * 64'(rmag);
          state <= B_ACC;
        end
        B_ACC: begin
          m2    <= m2_sum[64] ? '1 : m2_sum[63:0];
          state <= B_IDLE;
        end
        B_FDIV: begin
          if (div_done) begin
            sq_v   <= div_q;
            sq_res <= '0;
            sq_bit <= 64'd1 << 62;
            state  <= B_SQRT;
          end
        end
        B_SQRT: begin
          if (sq_fit) begin
            sq_v   <= sq_v - sq_t;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit == 64'd1) begin
            res_mean  <= mean;
            res_dev   <= sq_fit ? 32'((sq_res >> 1) + sq_bit) : 32'(sq_res >> 1);
            res_count <= (cnt_wide > 32'd63) ? 6'd63 : cnt_wide[5:0];
            res_valid <= 1'b1;
            state     <= B_DONE;
          end
        end
        B_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {2'b00, res_count, res_dev, res_mean};
            m_tuser  <= res_valid;
            m_tvalid <= 1'b1;
            cnt      <= '0;
            mean     <= '0;
            m2       <= '0;
            state    <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/frame_interval_statistics.sv
// The front walks back through the intervals of the history, one ring entry at a time; the
// back handles each good interval with two 32-step divides on the shared divider, a multiply
// and an accumulate, then ends a run that had good intervals with a 64-step divide and a 32-step square root.
// Each unit takes one request at a time; a run walks up to 63 intervals.
// Reset is synchronous; ring entries not yet written read as zero through the fill tracking.
module frame_interval_statistics #(
  parameter int HISTORY_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // frame_time_us
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // mean_rate, rate_deviation, good_count, zero pad
  output logic        m_tuser,   // stats_valid
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fis_pkg::*;

  fis_cfg_t  cfg;
  logic      fq_valid;
  logic      fq_ready;
  fis_item_t fq_data;
  logic      bq_valid;
  logic      bq_ready;
  fis_item_t bq_data;
  logic      cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.too_fast_us <= RESET_TOO_FAST;
      cfg.too_slow_us <= RESET_TOO_SLOW;
      cfg.check_fast  <= 1'b1;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_TOO_FAST:   cfg.too_fast_us <= pwdata;
        REG_TOO_SLOW:   cfg.too_slow_us <= pwdata;
        REG_CHECK_FAST: cfg.check_fast  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TOO_FAST:   prdata = cfg.too_fast_us;
      REG_TOO_SLOW:   prdata = cfg.too_slow_us;
      REG_CHECK_FAST: prdata = {31'd0, cfg.check_fast};
      default:        prdata = 32'd0;
    endcase
  end

  fis_front #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_stamp (s_tdata),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  fis_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (bq_valid),
    .out_ready (bq_ready),
    .out_data  (bq_data)
  );

  fis_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (bq_valid),
    .q_ready  (bq_ready),
    .q_data   (bq_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

FILE: bench/frame_interval_statistics_tb.sv
`timescale 1ns / 1ps

module frame_interval_statistics_tb;
  import fis_pkg::*;

  localparam int DEPTH = 64;
  localparam logic [63:0] RATE_Q12 = 64'd4096000000;

  typedef struct packed {
    logic [31:0] mean_rate;
    logic [31:0] rate_deviation;
    logic [5:0]  good_count;
    logic        stats_valid;
  } rate_stats_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  frame_interval_statistics i_dut (.*);

  always #2 clk = ~clk;

  // Predictor state.
  logic [31:0] stamps [DEPTH];
  int unsigned slot;
  int unsigned filled;
  logic [31:0] fast_limit;
  logic [31:0] slow_limit;
  logic        fast_check;

  logic [31:0] frame_queue [$];
  rate_stats_t stats_queue [$];
  int          errors = 0;
  bit          hold_sender = 1'b0;
  int          hold_receiver = 0;
  bit          in_taken = 1'b0;

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic bit interval_rejected(logic [31:0] iv);
    return iv == 0 || iv > slow_limit || (fast_check && iv < fast_limit);
  endfunction

  function automatic rate_stats_t predict_stats(logic [31:0] stamp);
    rate_stats_t r;
    int unsigned lim, cnt, nw, od;
    logic [31:0] iv;
    logic [63:0] mean, m2, x, dmag, rmag, prod, dev;
    cnt = 0;
    mean = 0;
    m2 = 0;
    stamps[slot] = stamp;
    slot = (slot + 1) % DEPTH;
    if (filled < DEPTH) filled++;
    lim = filled - 1;
    if (lim > DEPTH - 2) lim = DEPTH - 2;
    for (int unsigned j = 0; j <= lim; j++) begin
      nw = (slot + 2 * DEPTH - 1 - j) % DEPTH;
      od = (slot + 2 * DEPTH - 2 - j) % DEPTH;
      iv = stamps[nw] - stamps[od];
      if (interval_rejected(iv)) begin
        if (cnt != 0) break;
        continue;
      end
      x = RATE_Q12 / {32'd0, iv};
      cnt++;
      if (x >= mean) begin
        dmag = x - mean;
        mean = mean + dmag / 64'(cnt);
        rmag = x - mean;
      end else begin
        dmag = mean - x;
        mean = mean - dmag / 64'(cnt);
        rmag = mean - x;
      end
      prod = dmag * rmag;
      if (m2 > ~64'd0 - prod) m2 = ~64'd0;
      else m2 = m2 + prod;
    end
    r = '0;
    if (cnt != 0) begin
      dev = root64(m2 / 64'(cnt));
      r.mean_rate = mean[31:0];
      r.rate_deviation = dev[31:0];
      r.good_count = cnt > 63 ? 6'd63 : cnt[5:0];
      r.stats_valid = 1'b1;
    end
    return r;
  endfunction

  function automatic int unsigned gap_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Input handshake and prediction.
  always @(posedge clk) begin
    in_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      stats_queue.push_back(predict_stats(s_tdata));
    end
  end

  // Driver.
  int unsigned send_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || in_taken) begin
        if (send_gap > 0 || hold_sender || frame_queue.size() == 0) begin
          s_tvalid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end else begin
          s_tvalid <= 1'b1;
          s_tdata <= frame_queue.pop_front();
          send_gap = gap_length();
        end
      end
    end
  end

  // Receiver ready pattern.
  int unsigned recv_gap = 0;
  always @(negedge clk) begin
    if (hold_receiver > 0) begin
      m_tready <= 1'b0;
      hold_receiver--;
    end else if (recv_gap > 0) begin
      m_tready <= 1'b0;
      recv_gap--;
    end else begin
      m_tready <= 1'b1;
      recv_gap = gap_length();
    end
  end

  // Monitor.
  always @(posedge clk) begin
    rate_stats_t want;
    rate_stats_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.mean_rate = m_tdata[31:0];
      got.rate_deviation = m_tdata[63:32];
      got.good_count = m_tdata[69:64];
      got.stats_valid = m_tuser;
      if (stats_queue.size() == 0) begin
        $error("unexpected result %h", m_tdata);
        errors++;
      end else begin
        want = stats_queue.pop_front();
        if (got.mean_rate !== want.mean_rate) begin
          $error("mean_rate expected %0d actual %0d", want.mean_rate, got.mean_rate);
          errors++;
        end
        if (got.rate_deviation !== want.rate_deviation) begin
          $error("rate_deviation expected %0d actual %0d",
                 want.rate_deviation, got.rate_deviation);
          errors++;
        end
        if (got.good_count !== want.good_count) begin
          $error("good_count expected %0d actual %0d", want.good_count, got.good_count);
          errors++;
        end
        if (got.stats_valid !== want.stats_valid) begin
          $error("stats_valid expected %0d actual %0d", want.stats_valid, got.stats_valid);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(fis_reg_t idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TOO_FAST: fast_limit = value;
      REG_TOO_SLOW: slow_limit = value;
      default: fast_check = value[0];
    endcase
  endtask

  task automatic drain();
    while (frame_queue.size() != 0 || s_tvalid || stats_queue.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_limits(logic [31:0] fast, logic [31:0] slow, logic chk);
    drain();
    write_reg(REG_TOO_FAST, fast);
    write_reg(REG_TOO_SLOW, slow);
    write_reg(REG_CHECK_FAST, {31'd0, chk});
  endtask

  // A run of plausible frames with occasional hiccups.
  task automatic queue_frames(int n, logic [31:0] lo, logic [31:0] hi, int noise);
    logic [31:0] t;
    t = $urandom;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise) begin
        case ($urandom_range(0, 3))
          0: t = t;
          1: t = t - $urandom_range(1, 1000);
          2: t = t + $urandom_range(100000, 300000);
          default: t = $urandom;
        endcase
      end else begin
        t = t + $urandom_range(lo, hi);
      end
      frame_queue.push_back(t);
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) stamps[i] = '0;
    slot = 1;
    filled = 1;
    fast_limit = RESET_TOO_FAST;
    slow_limit = RESET_TOO_SLOW;
    fast_check = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: construction time, zero interval, too fast, too slow, wrap, backward.
    frame_queue.push_back(32'd16667);
    frame_queue.push_back(32'd16667);
    frame_queue.push_back(32'd33334);
    frame_queue.push_back(32'd33344);
    frame_queue.push_back(32'd50000);
    frame_queue.push_back(32'd150000);
    frame_queue.push_back(32'hFFFF_FFF0);
    frame_queue.push_back(32'd16000);
    frame_queue.push_back(32'd15000);
    frame_queue.push_back(32'd31000);
    frame_queue.push_back(32'hFFFF_FFFF);
    frame_queue.push_back(32'h0000_0000);
    drain();

    // Extremes: interval of one gives the largest rate; wide-open limits.
    set_limits(32'd0, 32'hFFFF_FFFF, 1'b0);
    frame_queue.push_back(32'd1);
    frame_queue.push_back(32'd2);
    frame_queue.push_back(32'd3);
    frame_queue.push_back(32'h8000_0003);
    frame_queue.push_back(32'hFFFF_FFFF);
    frame_queue.push_back(32'h5555_5555);
    frame_queue.push_back(32'hAAAA_AAAA);
    set_limits(32'hFFFF_FFFF, 32'd0, 1'b1);
    frame_queue.push_back(32'd100);
    frame_queue.push_back(32'd200);

    set_limits(RESET_TOO_FAST, RESET_TOO_SLOW, 1'b1);
    queue_frames(50, 15000, 20000, 3);
    drain();
    // Long receiver stall while the sender keeps offering.
    hold_receiver = 20000;
    queue_frames(10, 15000, 20000, 0);
    drain();
    hold_sender = 1'b1;
    drain();
    hold_sender = 1'b0;

    set_limits(32'd1000, 32'd5000, 1'b0);
    queue_frames(30, 500, 5500, 10);
    set_limits($urandom_range(0, 20), $urandom_range(100, 400), 1'b1);
    queue_frames(30, 1, 400, 15);
    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/fis_pkg.sv
rtl/fis_queue.sv
rtl/fis_front.sv
rtl/fis_div.sv
rtl/fis_back.sv
rtl/frame_interval_statistics.sv
bench/frame_interval_statistics_tb.sv
